// ===== rtl/cmvc_pkg.sv =====
// Shared types and constants for the cooler mode and vent controller.
`timescale 1ns / 1ps

package cmvc_pkg;

    // Operating modes
    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_IDLE  = 2'd1;
    localparam logic [1:0] MODE_RUN   = 2'd2;
    localparam logic [1:0] MODE_ERROR = 2'd3;

    // One-hot lamp codes
    localparam logic [3:0] LAMP_OFF   = 4'b1000;
    localparam logic [3:0] LAMP_IDLE  = 4'b0100;
    localparam logic [3:0] LAMP_RUN   = 4'b0001;
    localparam logic [3:0] LAMP_ERROR = 4'b0010;

    // Vent servo
    localparam logic [6:0] VENT_STEP = 7'd15;
    localparam logic [6:0] VENT_MAX  = 7'd90;

    // Joystick dead band edges
    localparam logic [9:0] JOY_OPEN_MAX  = 10'd412;
    localparam logic [9:0] JOY_CLOSE_MIN = 10'd612;

    // Register map (word index)
    localparam int         ADDR_W       = 4;
    localparam logic [1:0] REG_WATER_TH = 2'd0;
    localparam logic [1:0] REG_TEMP_TH  = 2'd1;
    localparam logic [1:0] REG_DEBOUNCE = 2'd2;

    // Register reset values
    localparam logic [9:0]         WATER_TH_RST = 10'd200;
    localparam logic signed [11:0] TEMP_TH_RST  = 12'sd700;
    localparam logic [15:0]        DEBOUNCE_RST = 16'd200;

    typedef struct packed {
        logic                button_level;
        logic [31:0]         now_ms;
        logic [9:0]          water_level;
        logic signed [11:0]  temperature;
        logic [9:0]          joystick_y;
    } sample_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       fan_on;
        logic [6:0] vent_angle_out;
        logic [3:0] indicator;
    } result_t;

    typedef struct packed {
        logic [9:0]          water_th;
        logic signed [11:0]  temp_th;
        logic [15:0]         debounce_ms;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic        fan;
        logic [6:0]  vent_pos;
        logic [31:0] last_press_ms;
        logic        prev_button;
    } state_t;

endpackage

// ===== rtl/cmvc_if.sv =====
// Valid/ready channel interfaces for control ticks and status results.
`timescale 1ns / 1ps

interface cmvc_sample_if;
    logic               valid;
    logic               ready;
    logic               button_level;
    logic [31:0]        now_ms;
    logic [9:0]         water_level;
    logic signed [11:0] temperature;
    logic [9:0]         joystick_y;

    modport source (
        output valid, button_level, now_ms, water_level, temperature, joystick_y,
        input  ready
    );
    modport sink (
        input  valid, button_level, now_ms, water_level, temperature, joystick_y,
        output ready
    );
endinterface

interface cmvc_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic       fan_on;
    logic [6:0] vent_angle_out;
    logic [3:0] indicator;

    modport source (
        output valid, mode, fan_on, vent_angle_out, indicator,
        input  ready
    );
    modport sink (
        input  valid, mode, fan_on, vent_angle_out, indicator,
        output ready
    );
endinterface

// ===== rtl/cmvc_step.sv =====
// Next-state and result logic for one control tick.
`timescale 1ns / 1ps

module cmvc_step
    import cmvc_pkg::*;
(
    input  sample_t smp,
    input  cfg_t    cfg,
    input  state_t  cur,
    output state_t  nxt,
    output result_t res
);

    logic [31:0] elapsed;
    logic        press;
    logic        low_water;
    logic [1:0]  mode_btn;
    logic [3:0]  lamp;

    assign elapsed   = smp.now_ms - cur.last_press_ms;
    assign press     = smp.button_level && !cur.prev_button
                       && (elapsed > {16'd0, cfg.debounce_ms});
    assign low_water = smp.water_level < cfg.water_th;
    assign mode_btn  = press ? ((cur.mode == MODE_OFF) ? MODE_IDLE : MODE_OFF) : cur.mode;

    always_comb
    begin
        unique case (cur.mode)
            MODE_OFF:  lamp = LAMP_OFF;
            MODE_IDLE: lamp = LAMP_IDLE;
            MODE_RUN:  lamp = LAMP_RUN;
            default:   lamp = LAMP_ERROR;
        endcase
    end

    always_comb
    begin
        nxt               = cur;
        nxt.prev_button   = smp.button_level;
        nxt.mode          = mode_btn;
        if (press)
        begin
            nxt.last_press_ms = smp.now_ms;
        end

        // vent: open wins over close, held at the travel limits
        if (smp.joystick_y <= JOY_OPEN_MAX && cur.vent_pos < VENT_MAX)
        begin
            nxt.vent_pos = cur.vent_pos + VENT_STEP;
        end
        else if (smp.joystick_y >= JOY_CLOSE_MIN && cur.vent_pos != 7'd0)
        begin
            nxt.vent_pos = cur.vent_pos - VENT_STEP;
        end

        unique case (mode_btn)
            MODE_IDLE:
            begin
                if (low_water)
                begin
                    nxt.mode = MODE_ERROR;
                end
                else if ($signed(smp.temperature) > $signed(cfg.temp_th))
                begin
                    nxt.mode = MODE_RUN;
                end
            end
            MODE_RUN:
            begin
                nxt.fan = 1'b1;
                if (low_water)
                begin
                    nxt.mode = MODE_ERROR;
                end
                else if ($signed(smp.temperature) < $signed(cfg.temp_th))
                begin
                    nxt.fan  = 1'b0;
                    nxt.mode = MODE_IDLE;
                end
            end
            MODE_ERROR:
            begin
                if (smp.water_level > cfg.water_th)
                begin
                    nxt.mode = MODE_IDLE;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign res.mode           = nxt.mode;
    assign res.fan_on         = nxt.fan;
    assign res.vent_angle_out = nxt.vent_pos;
    assign res.indicator      = lamp;

endmodule

// ===== rtl/cooler_mode_and_vent_controller_core.sv =====
// Top level of the cooler mode and vent controller: channels, registers, state.
`timescale 1ns / 1ps

// Cooler mode and vent controller. Each beat on the sample channel is one
// control tick (button level, ms time, water level, temperature, joystick);
// each tick yields exactly one beat on the result channel carrying the mode,
// fan drive, vent angle and the lamp of the mode held before the tick. The
// block takes one beat per cycle while the result channel is not stalled:
// a tick is registered on entry, the whole mode/vent/debounce update runs
// through combinational step logic, and the result is registered on exit,
// so a tick passes the input register and then the result register before
// its result is offered; the step logic feeding the state registers sets
// that rate. The user must write thresholds and the debounce window over
// the APB port only while no tick is in flight; the block does not check.
module cooler_mode_and_vent_controller_core
    import cmvc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // APB configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // channels
    cmvc_sample_if.sink         sample,
    cmvc_result_if.source       result
);

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    sample_t sample_reg;
    logic    sample_valid_reg;
    result_t result_reg;
    result_t result_next;
    logic    result_valid_reg;
    logic    out_free;
    logic    step_fire;
    logic    cfg_wr;

    // ---------------- configuration registers ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.water_th    <= WATER_TH_RST;
            cfg_reg.temp_th     <= TEMP_TH_RST;
            cfg_reg.debounce_ms <= DEBOUNCE_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_WATER_TH: cfg_reg.water_th    <= pwdata[9:0];
                REG_TEMP_TH:  cfg_reg.temp_th     <= pwdata[11:0];
                REG_DEBOUNCE: cfg_reg.debounce_ms <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_WATER_TH: prdata = {22'd0, cfg_reg.water_th};
            REG_TEMP_TH:  prdata = {{20{cfg_reg.temp_th[11]}}, cfg_reg.temp_th};
            REG_DEBOUNCE: prdata = {16'd0, cfg_reg.debounce_ms};
            default:      prdata = 32'd0;
        endcase
    end

    // ---------------- pipeline control ----------------
    // The step fires when a tick sits in the input register and the output
    // register is empty or being drained this cycle.
    assign out_free     = !result_valid_reg || result.ready;
    assign step_fire    = sample_valid_reg && out_free;
    assign sample.ready = !sample_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            sample_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            sample_reg.button_level <= sample.button_level;
            sample_reg.now_ms       <= sample.now_ms;
            sample_reg.water_level  <= sample.water_level;
            sample_reg.temperature  <= sample.temperature;
            sample_reg.joystick_y   <= sample.joystick_y;
        end
    end

    // ---------------- step logic ----------------
    cmvc_step u_step (
        .smp (sample_reg),
        .cfg (cfg_reg),
        .cur (state_reg),
        .nxt (state_next),
        .res (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode          <= MODE_OFF;
            state_reg.fan           <= 1'b0;
            state_reg.vent_pos      <= 7'd0;
            state_reg.last_press_ms <= 32'd0;
            state_reg.prev_button   <= 1'b0;
        end
        else if (step_fire)
        begin
            state_reg <= state_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            result_valid_reg <= sample_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            result_reg <= result_next;
        end
    end

    assign result.valid          = result_valid_reg;
    assign result.mode           = result_reg.mode;
    assign result.fan_on         = result_reg.fan_on;
    assign result.vent_angle_out = result_reg.vent_angle_out;
    assign result.indicator      = result_reg.indicator;

    // ---------------- assertions ----------------
    // vent never leaves its travel
    a_vent_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.vent_pos <= VENT_MAX)
        else $error("vent angle beyond travel");

    // fan only drops when running hands back to idle
    a_fan_off: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(state_reg.fan) |-> state_reg.mode == MODE_IDLE)
        else $error("fan cleared outside running-to-idle");

    // state moves only on a step
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step_fire |=> $stable(state_reg))
        else $error("state changed without a step");

    // leaving error for idle needs water above threshold
    a_err_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (step_fire && state_reg.mode == MODE_ERROR && state_next.mode == MODE_IDLE)
        |-> sample_reg.water_level > cfg_reg.water_th)
        else $error("error exit without water");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the cooler mode and vent controller core.
`timescale 1ns / 1ps

// Every control tick sent into the core is run through a local model of the
// mode machine, vent servo and button debounce. The model's status is queued
// and compared field by field with each status beat that leaves the core.
//
// Flow of the run:
//   - directed ticks under reset settings: threshold edges, debounce window
//     edges, time wrap, vent limits, presses in off, running and error
//   - register write/readback at all-zeros and all-ones
//   - random traffic under extreme and mid-range settings, one idling pattern per setting
//   - a long receiver hold-off while the sender keeps pushing ticks
//   - a sender pause until every status has come back
//   - random traffic back at the reset settings
// Settings are changed only while no tick is in flight.
module tb
    import cmvc_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 2000;   // cycles with no beat at all
    localparam int HOLD_CYCLES    = 300;    // long receiver hold-off
    localparam int TAIL_CYCLES    = 8;      // settle time after the final drain

    logic              clk   = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    cmvc_sample_if tick_ch ();
    cmvc_result_if status_ch ();

    cooler_mode_and_vent_controller_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .sample  (tick_ch),
        .result  (status_ch)
    );

    // Local model state and settings
    state_t      ctl_state;
    cfg_t        ctl_cfg;
    result_t     status_q[$];           // predicted statuses, oldest first

    // Traffic shaping
    int          gap_pct      = 0;      // chance per cycle the sender idles
    int          stall_pct    = 0;      // chance per cycle the receiver stalls
    int          hold_req_cnt = 0;      // bumped to ask for a long hold-off
    int          hold_seen    = 0;
    int          hold_left    = 0;
    logic [31:0] sim_ms;                // running ms clock for shaped ticks
    logic        btn_held;

    // Bookkeeping
    int          mismatch_count   = 0;
    int          ticks_sent       = 0;
    int          statuses_checked = 0;
    int          settings_used    = 0;
    int          quiet_cycles     = 0;
    int          mode_hits[4]     = '{0, 0, 0, 0};

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Model of one control tick. Lamp comes from the mode before the tick;
    // the button edge is handled first, then vent, then the mode machine
    // on the mode left by the button.
    // ------------------------------------------------------------------
    function automatic result_t predict_status(input sample_t t);
        result_t r;
        logic    low_water;
        case (ctl_state.mode)
            MODE_OFF:  r.indicator = LAMP_OFF;
            MODE_IDLE: r.indicator = LAMP_IDLE;
            MODE_RUN:  r.indicator = LAMP_RUN;
            default:   r.indicator = LAMP_ERROR;
        endcase
        low_water = t.water_level < ctl_cfg.water_th;

        // debounce: wrapped elapsed time must strictly exceed the window
        if (t.button_level && !ctl_state.prev_button &&
            (t.now_ms - ctl_state.last_press_ms) > 32'(ctl_cfg.debounce_ms))
        begin
            ctl_state.mode = (ctl_state.mode == MODE_OFF) ? MODE_IDLE : MODE_OFF;
            ctl_state.last_press_ms = t.now_ms;
        end
        ctl_state.prev_button = t.button_level;

        if (t.joystick_y <= JOY_OPEN_MAX && ctl_state.vent_pos < VENT_MAX)
            ctl_state.vent_pos = ctl_state.vent_pos + VENT_STEP;
        else if (t.joystick_y >= JOY_CLOSE_MIN && ctl_state.vent_pos != 7'd0)
            ctl_state.vent_pos = ctl_state.vent_pos - VENT_STEP;

        case (ctl_state.mode)
            MODE_IDLE:
            begin
                if (low_water)
                    ctl_state.mode = MODE_ERROR;
                else if ($signed(t.temperature) > $signed(ctl_cfg.temp_th))
                    ctl_state.mode = MODE_RUN;
            end
            MODE_RUN:
            begin
                ctl_state.fan = 1'b1;
                if (low_water)
                    ctl_state.mode = MODE_ERROR;    // fan stays on
                else if ($signed(t.temperature) < $signed(ctl_cfg.temp_th))
                begin
                    ctl_state.fan  = 1'b0;
                    ctl_state.mode = MODE_IDLE;
                end
            end
            MODE_ERROR:
            begin
                if (t.water_level > ctl_cfg.water_th)
                    ctl_state.mode = MODE_IDLE;
            end
            default:
            begin
            end
        endcase

        r.mode           = ctl_state.mode;
        r.fan_on         = ctl_state.fan;
        r.vent_angle_out = ctl_state.vent_pos;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Random tick. Most ticks follow a running ms clock and a held button so
    // the debounce window and the thresholds matter; the rest are raw noise.
    // ------------------------------------------------------------------
    function automatic sample_t make_tick();
        sample_t     t;
        logic [31:0] rnd;
        rnd            = $urandom;
        t.now_ms       = rnd;
        rnd            = $urandom;
        t.button_level = rnd[0];
        t.water_level  = rnd[10:1];
        t.temperature  = rnd[22:11];
        rnd            = $urandom;
        t.joystick_y   = rnd[9:0];
        if ($urandom_range(99) < 85)
        begin
            sim_ms   = sim_ms + $urandom_range(int'(ctl_cfg.debounce_ms) + 1);
            t.now_ms = sim_ms;
            if ($urandom_range(99) < 35)
                btn_held = !btn_held;
            t.button_level = btn_held;
            // water hugging the threshold
            if ($urandom_range(9) < 4)
                t.water_level = ctl_cfg.water_th + 10'($urandom_range(6)) - 10'd3;
            case ($urandom_range(4))
                0, 1:    t.temperature = ctl_cfg.temp_th + 12'($urandom_range(6)) - 12'd3;
                2, 3:    t.temperature = 12'($urandom_range(2400) - 400);
                default: ;  // raw 12-bit pattern
            endcase
            // joystick right on the dead band edges
            if ($urandom_range(3) == 0)
            begin
                case ($urandom_range(3))
                    0:       t.joystick_y = JOY_OPEN_MAX;
                    1:       t.joystick_y = JOY_OPEN_MAX + 10'd1;
                    2:       t.joystick_y = JOY_CLOSE_MIN - 10'd1;
                    default: t.joystick_y = JOY_CLOSE_MIN;
                endcase
            end
        end
        return t;
    endfunction

    // ------------------------------------------------------------------
    // Tick channel. valid stays high after a beat; the next call either
    // reuses it or drops it for a random gap.
    // ------------------------------------------------------------------
    task automatic send_tick(input sample_t t);
        while ($urandom_range(99) < gap_pct)
        begin
            tick_ch.valid <= 1'b0;
            @(posedge clk);
        end
        tick_ch.valid        <= 1'b1;
        tick_ch.button_level <= t.button_level;
        tick_ch.now_ms       <= t.now_ms;
        tick_ch.water_level  <= t.water_level;
        tick_ch.temperature  <= t.temperature;
        tick_ch.joystick_y   <= t.joystick_y;
        do @(posedge clk); while (!tick_ch.ready);
        status_q.push_back(predict_status(t));
        ticks_sent++;
    endtask

    task automatic send_fields(input int btn, input logic [31:0] now, input int water,
                               input int temp, input int joy);
        sample_t t;
        t.button_level = 1'(btn);
        t.now_ms       = now;
        t.water_level  = 10'(water);
        t.temperature  = 12'(temp);
        t.joystick_y   = 10'(joy);
        send_tick(t);
    endtask

    task automatic random_burst(input int count);
        repeat (count) send_tick(make_tick());
    endtask

    // Stop offering ticks and wait for every predicted status to come back.
    task automatic drain_status();
        tick_ch.valid <= 1'b0;
        @(posedge clk);
        while (status_q.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // APB: setup cycle then access cycle; data sampled at the access edge.
    // ------------------------------------------------------------------
    task automatic apb_xfer(input logic is_write, input logic [1:0] idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata    = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write a register, mirror it in the model, read it back.
    task automatic set_register(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] rd;
        logic [31:0] mask;
        apb_xfer(1'b1, idx, value, rd);
        case (idx)
            REG_WATER_TH:
            begin
                ctl_cfg.water_th = value[9:0];
                mask = 32'h0000_03FF;
            end
            REG_TEMP_TH:
            begin
                ctl_cfg.temp_th = value[11:0];
                mask = 32'h0000_0FFF;
            end
            REG_DEBOUNCE:
            begin
                ctl_cfg.debounce_ms = value[15:0];
                mask = 32'h0000_FFFF;
            end
            default: mask = 32'h0;
        endcase
        apb_xfer(1'b0, idx, 32'h0, rd);
        if ((rd & mask) !== (value & mask))
        begin
            mismatch_count++;
            $error("register %0d readback: expected %0h, got %0h", idx, value & mask, rd & mask);
        end
    endtask

    task automatic apply_setting(input int water, input int temp, input int debounce);
        drain_status();
        set_register(REG_WATER_TH, 32'(water));
        set_register(REG_TEMP_TH, 32'(temp));
        set_register(REG_DEBOUNCE, 32'(debounce));
        sim_ms = $urandom;
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // Status channel: check each beat, then pick ready for the next cycle.
    // ------------------------------------------------------------------
    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (status_ch.valid && status_ch.ready)
            begin
                got.mode           = status_ch.mode;
                got.fan_on         = status_ch.fan_on;
                got.vent_angle_out = status_ch.vent_angle_out;
                got.indicator      = status_ch.indicator;
                statuses_checked++;
                mode_hits[got.mode]++;
                if (status_q.size() == 0)
                begin
                    mismatch_count++;
                    $error("status beat with no tick outstanding (mode %0d)", got.mode);
                end
                else
                begin
                    want = status_q.pop_front();
                    compare_field("mode", 32'(want.mode), 32'(got.mode));
                    compare_field("fan_on", 32'(want.fan_on), 32'(got.fan_on));
                    compare_field("vent_angle_out", 32'(want.vent_angle_out),
                                  32'(got.vent_angle_out));
                    compare_field("indicator", 32'(want.indicator), 32'(got.indicator));
                end
            end
            if (hold_seen != hold_req_cnt)
            begin
                hold_seen = hold_req_cnt;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                status_ch.ready <= 1'b0;
            end
            else
                status_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: any beat on either channel or an APB access counts as progress.
    initial
    begin
        @(posedge rst_n);
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((tick_ch.valid && tick_ch.ready) || (status_ch.valid && status_ch.ready) ||
                (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no beat for %0d cycles, %0d statuses outstanding",
                 WATCHDOG_LIMIT, status_q.size());
        $display("** cooler_mode_and_vent_controller_core: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings: water 200, temp 700, debounce 200. Comments give the
    // expected mode and vent after each tick.
    task automatic test_directed_cases();
        gap_pct   = 0;
        stall_pct = 0;
        send_fields(0, 32'd0,   1023, 2000, 1023);  // off; close at 0 holds 0
        send_fields(1, 32'd200, 1023, 2000, 0);     // elapsed == window: rejected; vent 15
        send_fields(0, 32'd201, 1023, 2000, 0);     // release; vent 30
        send_fields(1, 32'd201, 1023, 2000, 0);     // press: off->idle->running; vent 45
        send_fields(1, 32'd300, 200,  700,  412);   // held, water and temp at threshold
        send_fields(0, 32'd300, 199,  2000, 0);     // low water: running->error, fan kept
        send_fields(0, 32'd300, 200,  0,    0);     // water at threshold: stays in error
        send_fields(0, 32'd300, 201,  0,    0);     // error->idle; open at 90 holds
        send_fields(0, 32'd300, 1023, 700,  413);   // temp at threshold: idle stays
        send_fields(0, 32'd300, 1023, 701,  611);   // idle->running
        send_fields(0, 32'd300, 1023, 699,  612);   // cool: fan cleared, running->idle
        send_fields(0, 32'd300, 1023, -400, 1023);  // coldest in range
        send_fields(0, 32'd300, 0,    2000, 1023);  // empty tank: idle->error
        send_fields(1, 32'd402, 1023, 2000, 1023);  // press in error -> off
        send_fields(0, 32'd402, 1023, 2000, 1023);
        send_fields(1, 32'hFFFF_FFF0, 1023, 2000, 1023);  // late time: off->idle->running
        send_fields(0, 32'hFFFF_FFF0, 1023, 2000, 1023);  // running, fan on
        send_fields(1, 32'h0000_0100, 1023, 2000, 512);   // across the wrap: running->off
        send_fields(0, 32'hFFFF_FFFF, 1023, -2048, 512);  // most negative pattern
        send_fields(1, 32'hFFFF_FFFF, 1023, 2047,  512);  // off->idle->running
        drain_status();
    endtask

    task automatic test_register_readback();
        set_register(REG_WATER_TH, 32'hFFFF_FFFF);
        set_register(REG_WATER_TH, 32'h0);
        set_register(REG_TEMP_TH, 32'hFFFF_FFFF);
        set_register(REG_TEMP_TH, 32'h0);
        set_register(REG_DEBOUNCE, 32'hFFFF_FFFF);
        set_register(REG_DEBOUNCE, 32'h0);
    endtask

    // One idling pattern per setting; the first two settings sit at the register extremes.
    task automatic test_idle_patterns();
        apply_setting(1023, -2048, 0);
        gap_pct   = 0;
        stall_pct = 0;
        random_burst(200);
        apply_setting(0, 2047, 65535);
        gap_pct   = 81;
        stall_pct = 0;
        random_burst(200);
        apply_setting(512, -400, 50);
        gap_pct   = 0;
        stall_pct = 81;
        random_burst(200);
        apply_setting(100, 2000, 1000);
        gap_pct   = 34;
        stall_pct = 34;
        random_burst(200);
        drain_status();
    endtask

    // Receiver goes dark while ticks keep coming: the core must stall its input.
    task automatic test_input_backpressure();
        apply_setting(300, 650, 10);
        gap_pct       = 0;
        stall_pct     = 0;
        hold_req_cnt <= hold_req_cnt + 1;
        random_burst(60);
        drain_status();
    endtask

    task automatic test_sender_pause();
        apply_setting(250, 720, 100);
        gap_pct   = 34;
        stall_pct = 34;
        random_burst(60);
        drain_status();
        random_burst(60);
        drain_status();
    endtask

    task automatic test_default_settings();
        apply_setting(int'(WATER_TH_RST), int'(TEMP_TH_RST), int'(DEBOUNCE_RST));
        gap_pct   = 34;
        stall_pct = 34;
        random_burst(120);
        drain_status();
    endtask

    initial
    begin
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        tick_ch.valid        = 1'b0;
        tick_ch.button_level = 1'b0;
        tick_ch.now_ms       = '0;
        tick_ch.water_level  = '0;
        tick_ch.temperature  = '0;
        tick_ch.joystick_y   = '0;
        status_ch.ready      = 1'b0;
        ctl_state            = '0;
        ctl_cfg.water_th     = WATER_TH_RST;
        ctl_cfg.temp_th      = TEMP_TH_RST;
        ctl_cfg.debounce_ms  = DEBOUNCE_RST;
        sim_ms               = '0;
        btn_held             = 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_register_readback();
        test_idle_patterns();
        test_input_backpressure();
        test_sender_pause();
        test_default_settings();

        drain_status();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d control ticks and checked %0d status beats under %0d settings,",
                 ticks_sent, statuses_checked, settings_used + 1);
        $display("ending in off/idle/running/error %0d/%0d/%0d/%0d times, all idling patterns.",
                 mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3]);
        if (mismatch_count == 0 && status_q.size() == 0)
            $display("** cooler_mode_and_vent_controller_core: PASSED **");
        else
            $display("** cooler_mode_and_vent_controller_core: FAILED **");
        $finish;
    end

endmodule
